>>> sv/lmds_pkg.sv
package lmds_pkg;

  localparam int CNT_W   = 4;
  localparam int TIMER_W = 10;
  localparam int NUM_SW  = 4;

  // switch slots in the debounce bank
  localparam int SW_LEFT     = 0;
  localparam int SW_VERTICAL = 1;
  localparam int SW_RIGHT    = 2;
  localparam int SW_TRAVEL   = 3;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_UNLOCK = 2'd1;
  localparam logic [1:0] OP_LOCK   = 2'd2;

  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_DIR0 = 2'd1;
  localparam logic [1:0] DRV_DIR1 = 2'd2;

  localparam logic [1:0] POS_MIDDLE   = 2'd0;
  localparam logic [1:0] POS_LOCKED   = 2'd1;
  localparam logic [1:0] POS_UNLOCKED = 2'd2;

  localparam logic [1:0] OUT_NONE  = 2'd0;
  localparam logic [1:0] OUT_DONE  = 2'd1;
  localparam logic [1:0] OUT_THERE = 2'd2;
  localparam logic [1:0] OUT_FAIL  = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_UNLOCK = 2'd1,
    MODE_LOCK   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_ENTRY    = 3'd0,
    ST_RUN      = 3'd1,
    ST_OVERRUN  = 3'd2,
    ST_SETTLE   = 3'd3,
    ST_BACKOFF  = 3'd4,
    ST_SEEKBACK = 3'd5,
    ST_PREFINAL = 3'd6,
    ST_FINAL    = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    REG_HAND_LEFT      = 3'd0,
    REG_DRIVE_TIMEOUT  = 3'd1,
    REG_LOCK_SETTLE    = 3'd2,
    REG_UNLOCK_SETTLE  = 3'd3,
    REG_LOCK_BACKOFF   = 3'd4,
    REG_UNLOCK_BACKOFF = 3'd5,
    REG_FINAL_RUN      = 3'd6,
    REG_OVERRUN_TICKS  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic               hand_left;
    logic [TIMER_W-1:0] drive_timeout;
    logic [7:0]         lock_settle;
    logic [7:0]         unlock_settle;
    logic [7:0]         lock_backoff;
    logic [7:0]         unlock_backoff;
    logic [7:0]         final_run;
    logic [3:0]         overrun_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    step_e              step;
    logic [TIMER_W-1:0] timer;
    logic               travel_latched;
    logic [1:0]         drive;
  } seq_state_t;

  typedef struct packed {
    logic [NUM_SW-1:0] on;     // debounced, active high
    logic [NUM_SW-1:0] raw_n;  // raw levels, active low
    logic              back_on;
  } sw_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic       busy_res;
    logic [1:0] position;
    logic [1:0] outcome;
  } res_t;

endpackage

>>> sv/lmds_seq.sv
module lmds_seq (
  input  lmds_pkg::cfg_t       cfg_i,
  input  lmds_pkg::seq_state_t cur_i,   // timer already decremented for this tick
  input  lmds_pkg::sw_t        sw_i,
  output lmds_pkg::seq_state_t nxt_o,
  output logic [1:0]           outcome_o
);
  import lmds_pkg::*;

  logic               is_lock;
  logic [1:0]         fwd;
  logic [1:0]         rev;
  logic [1:0]         end_idx;
  logic               end_on;
  logic               raw_end_n;
  logic               raw_travel;
  logic               tmr_zero;
  logic               travel_chg;
  logic [TIMER_W-1:0] settle_ticks;
  logic [TIMER_W-1:0] backoff_ticks;

  always_comb begin
    is_lock       = (cur_i.mode == MODE_LOCK);
    if (is_lock) begin
      fwd = cfg_i.hand_left ? DRV_DIR1 : DRV_DIR0;
    end else begin
      fwd = cfg_i.hand_left ? DRV_DIR0 : DRV_DIR1;
    end
    rev           = (fwd == DRV_DIR0) ? DRV_DIR1 : DRV_DIR0;
    if (is_lock) begin
      end_idx = cfg_i.hand_left ? 2'(SW_LEFT) : 2'(SW_RIGHT);
    end else begin
      end_idx = 2'(SW_VERTICAL);
    end
    end_on        = sw_i.on[end_idx];
    raw_end_n     = sw_i.raw_n[end_idx];
    raw_travel    = sw_i.raw_n[SW_TRAVEL];
    tmr_zero      = (cur_i.timer == '0);
    travel_chg    = (cur_i.travel_latched != raw_travel);
    settle_ticks  = is_lock ? TIMER_W'(cfg_i.lock_settle) : TIMER_W'(cfg_i.unlock_settle);
    backoff_ticks = is_lock ? TIMER_W'(cfg_i.lock_backoff) : TIMER_W'(cfg_i.unlock_backoff);

    nxt_o     = cur_i;
    outcome_o = OUT_NONE;

    unique case (cur_i.step)
      ST_ENTRY: begin
        if (end_on) begin
          nxt_o.drive = DRV_STOP;
          nxt_o.mode  = MODE_IDLE;
          nxt_o.step  = ST_ENTRY;
          outcome_o   = OUT_THERE;
        end else begin
          nxt_o.drive = fwd;
          nxt_o.timer = cfg_i.drive_timeout;
          nxt_o.step  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tmr_zero) begin
          nxt_o.drive = DRV_STOP;
          nxt_o.mode  = MODE_IDLE;
          nxt_o.step  = ST_ENTRY;
          outcome_o   = OUT_FAIL;
        end else if (end_on || !raw_end_n) begin
          if (cfg_i.overrun_ticks == '0) begin
            nxt_o.drive = DRV_STOP;
            nxt_o.timer = settle_ticks;
            nxt_o.step  = ST_SETTLE;
          end else begin
            nxt_o.timer = TIMER_W'(cfg_i.overrun_ticks);
            nxt_o.step  = ST_OVERRUN;
          end
        end
      end
      ST_OVERRUN: begin
        if (tmr_zero) begin
          nxt_o.drive = DRV_STOP;
          nxt_o.timer = settle_ticks;
          nxt_o.step  = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (tmr_zero) begin
          nxt_o.travel_latched = raw_travel;
          nxt_o.drive          = rev;
          nxt_o.timer          = backoff_ticks;
          nxt_o.step           = ST_BACKOFF;
        end
      end
      ST_BACKOFF: begin
        // a travel switch change cuts the backoff short
        if (tmr_zero || travel_chg) begin
          nxt_o.timer = backoff_ticks;
          nxt_o.step  = is_lock ? ST_SEEKBACK : ST_PREFINAL;
        end
      end
      ST_SEEKBACK: begin
        if (tmr_zero) begin
          nxt_o.drive = DRV_STOP;
          nxt_o.mode  = MODE_IDLE;
          nxt_o.step  = ST_ENTRY;
          outcome_o   = OUT_FAIL;
        end else if (sw_i.back_on || travel_chg) begin
          nxt_o.timer = '0;
          nxt_o.step  = ST_PREFINAL;
        end
      end
      ST_PREFINAL: begin
        if (tmr_zero) begin
          nxt_o.drive = rev;
          nxt_o.timer = TIMER_W'(cfg_i.final_run);
          nxt_o.step  = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (tmr_zero) begin
          nxt_o.drive = DRV_STOP;
          nxt_o.mode  = MODE_IDLE;
          nxt_o.step  = ST_ENTRY;
          outcome_o   = OUT_DONE;
        end
      end
    endcase
  end

endmodule

>>> sv/lock_motor_drive_sequencer_core.sv
// A request's result is registered in the output register, or first in the skid entry while the output is held.
// Throughput: one request per cycle; the whole step runs between the sequencer state
// registers and a two-entry result buffer, and input stalls only while both entries are full.
// Reset: sequence idle, timer and debounce counters zero, motor stopped, result buffer
// empty, configuration registers at their default values.
module lock_motor_drive_sequencer_core #(
  parameter int DEBOUNCE_MAX = 8,
  parameter int DEBOUNCE_ON  = 5,
  parameter int DEBOUNCE_OFF = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic        left_level_n_i,
  input  logic        vertical_n_i,
  input  logic        right_level_n_i,
  input  logic        travel_n_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  motor_drive_o,
  output logic        busy_res_o,
  output logic [1:0]  position_o,
  output logic [1:0]  outcome_o
);
  import lmds_pkg::*;

  cfg_t       cfg_q;
  reg_idx_e   reg_idx;
  logic       cfg_wr;

  seq_state_t st_q, st_d, st_tick, st_seq;
  logic [CNT_W-1:0] cnt_q [NUM_SW];
  logic [CNT_W-1:0] cnt_d [NUM_SW];
  logic [CNT_W-1:0] cnt_tick [NUM_SW];
  logic [NUM_SW-1:0] raw_n;
  sw_t        sw;
  logic [1:0] seq_outcome;
  res_t       res;

  logic       in_acc;
  logic       out_take;
  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  res_t       out_q, out_d, skid_q, skid_d;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HAND_LEFT:      prdata = 32'(cfg_q.hand_left);
      REG_DRIVE_TIMEOUT:  prdata = 32'(cfg_q.drive_timeout);
      REG_LOCK_SETTLE:    prdata = 32'(cfg_q.lock_settle);
      REG_UNLOCK_SETTLE:  prdata = 32'(cfg_q.unlock_settle);
      REG_LOCK_BACKOFF:   prdata = 32'(cfg_q.lock_backoff);
      REG_UNLOCK_BACKOFF: prdata = 32'(cfg_q.unlock_backoff);
      REG_FINAL_RUN:      prdata = 32'(cfg_q.final_run);
      REG_OVERRUN_TICKS:  prdata = 32'(cfg_q.overrun_ticks);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hand_left      <= 1'b0;
      cfg_q.drive_timeout  <= TIMER_W'(400);
      cfg_q.lock_settle    <= 8'd50;
      cfg_q.unlock_settle  <= 8'd100;
      cfg_q.lock_backoff   <= 8'd50;
      cfg_q.unlock_backoff <= 8'd30;
      cfg_q.final_run      <= 8'd10;
      cfg_q.overrun_ticks  <= 4'd2;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_HAND_LEFT:      cfg_q.hand_left      <= pwdata[0];
        REG_DRIVE_TIMEOUT:  cfg_q.drive_timeout  <= pwdata[TIMER_W-1:0];
        REG_LOCK_SETTLE:    cfg_q.lock_settle    <= pwdata[7:0];
        REG_UNLOCK_SETTLE:  cfg_q.unlock_settle  <= pwdata[7:0];
        REG_LOCK_BACKOFF:   cfg_q.lock_backoff   <= pwdata[7:0];
        REG_UNLOCK_BACKOFF: cfg_q.unlock_backoff <= pwdata[7:0];
        REG_FINAL_RUN:      cfg_q.final_run      <= pwdata[7:0];
        REG_OVERRUN_TICKS:  cfg_q.overrun_ticks  <= pwdata[3:0];
      endcase
    end
  end

  // ---------------- tick: timer and debounce ----------------
  assign raw_n = {travel_n_i, right_level_n_i, vertical_n_i, left_level_n_i};

  always_comb begin
    st_tick = st_q;
    if (st_q.timer != '0) begin
      st_tick.timer = st_q.timer - TIMER_W'(1);
    end
    for (int i = 0; i < NUM_SW; i++) begin
      cnt_tick[i] = cnt_q[i];
      if (!raw_n[i]) begin
        if (cnt_q[i] < CNT_W'(DEBOUNCE_MAX)) cnt_tick[i] = cnt_q[i] + CNT_W'(1);
      end else begin
        if (cnt_q[i] != '0) cnt_tick[i] = cnt_q[i] - CNT_W'(1);
      end
      sw.on[i] = (cnt_tick[i] > CNT_W'(DEBOUNCE_ON));
    end
    sw.raw_n   = raw_n;
    sw.back_on = (cnt_tick[SW_TRAVEL] < CNT_W'(DEBOUNCE_OFF));
  end

  lmds_seq u_seq (
    .cfg_i     (cfg_q),
    .cur_i     (st_tick),
    .sw_i      (sw),
    .nxt_o     (st_seq),
    .outcome_o (seq_outcome)
  );

  // ---------------- request decode and result ----------------
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    res.outcome = OUT_NONE;
    if (operation_i == OP_TICK) begin
      cnt_d = cnt_tick;
      if (st_q.mode == MODE_IDLE) begin
        st_d       = st_tick;
        st_d.drive = DRV_STOP;
      end else begin
        st_d        = st_seq;
        res.outcome = seq_outcome;
      end
    end else if ((operation_i == OP_UNLOCK || operation_i == OP_LOCK) &&
                 st_q.mode == MODE_IDLE) begin
      st_d.mode = (operation_i == OP_UNLOCK) ? MODE_UNLOCK : MODE_LOCK;
      st_d.step = ST_ENTRY;
    end

    res.motor_drive = st_d.drive;
    res.busy_res    = (st_d.mode != MODE_IDLE);
    // position follows the counters as they stand after this request
    if (cfg_q.hand_left ? (cnt_d[SW_LEFT] > CNT_W'(DEBOUNCE_ON))
                        : (cnt_d[SW_RIGHT] > CNT_W'(DEBOUNCE_ON))) begin
      res.position = POS_LOCKED;
    end else if (cnt_d[SW_VERTICAL] > CNT_W'(DEBOUNCE_ON)) begin
      res.position = POS_UNLOCKED;
    end else begin
      res.position = POS_MIDDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode           <= MODE_IDLE;
      st_q.step           <= ST_ENTRY;
      st_q.timer          <= '0;
      st_q.travel_latched <= 1'b0;
      st_q.drive          <= DRV_STOP;
      for (int i = 0; i < NUM_SW; i++) cnt_q[i] <= '0;
    end else if (in_acc) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // ---------------- two-entry result buffer ----------------
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign motor_drive_o = out_q.motor_drive;
  assign busy_res_o    = out_q.busy_res;
  assign position_o    = out_q.position;
  assign outcome_o     = out_q.outcome;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_motor_idle_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == MODE_IDLE) |-> (st_q.drive == DRV_STOP))
    else $error("motor driven while no sequence runs");

  a_cmd_starts_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && st_q.mode == MODE_IDLE &&
     (operation_i == OP_UNLOCK || operation_i == OP_LOCK))
    |=> (st_q.step == ST_ENTRY && st_q.mode != MODE_IDLE))
    else $error("accepted command did not start a sequence");

  a_result_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request left no result");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lmds_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int DEB_MAX         = 8;
  localparam int DEB_ON          = 5;
  localparam int DEB_OFF         = 3;
  localparam int NUM_REGS        = 8;
  localparam int NUM_DIR         = 17;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int CYCLE_LIMIT     = 200000;

  // operation code that the block must ignore
  localparam logic [1:0] OP_RSVD = 2'd3;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_END_STUCK,
    FAULT_TRAVEL_STUCK
  } fault_e;

  typedef struct {
    logic [1:0] op;
    logic [3:0] raw_n;  // {travel, right, vertical, left}, active low
    bit         fixed;
    res_t       res;
  } dir_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [4:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i     = OP_TICK;
  logic        left_level_n_i  = 1'b1;
  logic        vertical_n_i    = 1'b1;
  logic        right_level_n_i = 1'b1;
  logic        travel_n_i      = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  motor_drive_o;
  logic        busy_res_o;
  logic [1:0]  position_o;
  logic [1:0]  outcome_o;

  lock_motor_drive_sequencer_core #(
    .DEBOUNCE_MAX(DEB_MAX),
    .DEBOUNCE_ON (DEB_ON),
    .DEBOUNCE_OFF(DEB_OFF)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .left_level_n_i (left_level_n_i),
    .vertical_n_i   (vertical_n_i),
    .right_level_n_i(right_level_n_i),
    .travel_n_i     (travel_n_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .motor_drive_o  (motor_drive_o),
    .busy_res_o     (busy_res_o),
    .position_o     (position_o),
    .outcome_o      (outcome_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------
  cfg_t cfg = '{hand_left: 1'b0, drive_timeout: 10'd400, lock_settle: 8'd50,
                unlock_settle: 8'd100, lock_backoff: 8'd50, unlock_backoff: 8'd30,
                final_run: 8'd10, overrun_ticks: 4'd2};

  mode_e              seq_mode  = MODE_IDLE;
  step_e              seq_step  = ST_ENTRY;
  logic [TIMER_W-1:0] seq_timer = '0;
  logic [CNT_W-1:0]   deb_cnt [NUM_SW] = '{default: '0};
  logic               trav_lat  = 1'b0;
  logic [1:0]         drive_lvl = DRV_STOP;

  function automatic bit sw_on(int i);
    return deb_cnt[i] > DEB_ON;
  endfunction

  function automatic bit back_on();
    return deb_cnt[SW_TRAVEL] < DEB_OFF;
  endfunction

  function automatic int lock_sw();
    return cfg.hand_left ? SW_LEFT : SW_RIGHT;
  endfunction

  function automatic logic [1:0] bolt_position();
    if (sw_on(lock_sw())) return POS_LOCKED;
    if (sw_on(SW_VERTICAL)) return POS_UNLOCKED;
    return POS_MIDDLE;
  endfunction

  function automatic logic [1:0] seq_end(logic [1:0] code);
    drive_lvl = DRV_STOP;
    seq_mode  = MODE_IDLE;
    seq_step  = ST_ENTRY;
    return code;
  endfunction

  function automatic void enter_settle(bit lk);
    drive_lvl = DRV_STOP;
    seq_timer = lk ? TIMER_W'(cfg.lock_settle) : TIMER_W'(cfg.unlock_settle);
    seq_step  = ST_SETTLE;
  endfunction

  // one tick of the running lock/unlock sequence
  function automatic logic [1:0] seq_advance(logic [3:0] raw_n);
    bit         lk;
    logic [1:0] fwd;
    logic [1:0] rev;
    logic [1:0] oc;
    int         end_i;
    lk = (seq_mode == MODE_LOCK);
    if (lk) fwd = cfg.hand_left ? DRV_DIR1 : DRV_DIR0;
    else fwd = cfg.hand_left ? DRV_DIR0 : DRV_DIR1;
    rev   = (fwd == DRV_DIR0) ? DRV_DIR1 : DRV_DIR0;
    end_i = lk ? lock_sw() : SW_VERTICAL;
    oc    = OUT_NONE;
    case (seq_step)
      ST_ENTRY: begin
        if (sw_on(end_i)) begin
          oc = seq_end(OUT_THERE);
        end else begin
          drive_lvl = fwd;
          seq_timer = cfg.drive_timeout;
          seq_step  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (seq_timer == 0) begin
          oc = seq_end(OUT_FAIL);
        end else if (sw_on(end_i) || !raw_n[end_i]) begin
          if (cfg.overrun_ticks == 0) begin
            enter_settle(lk);
          end else begin
            seq_timer = TIMER_W'(cfg.overrun_ticks);
            seq_step  = ST_OVERRUN;
          end
        end
      end
      ST_OVERRUN: begin
        if (seq_timer == 0) enter_settle(lk);
      end
      ST_SETTLE: begin
        if (seq_timer == 0) begin
          trav_lat  = raw_n[SW_TRAVEL];
          drive_lvl = rev;
          seq_timer = lk ? TIMER_W'(cfg.lock_backoff) : TIMER_W'(cfg.unlock_backoff);
          seq_step  = ST_BACKOFF;
        end
      end
      ST_BACKOFF: begin
        if (trav_lat != raw_n[SW_TRAVEL]) seq_timer = '0;
        if (seq_timer == 0) begin
          seq_timer = lk ? TIMER_W'(cfg.lock_backoff) : TIMER_W'(cfg.unlock_backoff);
          seq_step  = lk ? ST_SEEKBACK : ST_PREFINAL;
        end
      end
      ST_SEEKBACK: begin
        if (seq_timer == 0) begin
          oc = seq_end(OUT_FAIL);
        end else if (back_on() || trav_lat != raw_n[SW_TRAVEL]) begin
          seq_timer = '0;
          seq_step  = ST_PREFINAL;
        end
      end
      ST_PREFINAL: begin
        if (seq_timer == 0) begin
          drive_lvl = rev;
          seq_timer = TIMER_W'(cfg.final_run);
          seq_step  = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (seq_timer == 0) oc = seq_end(OUT_DONE);
      end
    endcase
    return oc;
  endfunction

  function automatic res_t lock_seq_step(logic [1:0] op, logic [3:0] raw_n);
    res_t       r;
    logic [1:0] oc;
    oc = OUT_NONE;
    if (op == OP_TICK) begin
      if (seq_timer != 0) seq_timer = seq_timer - TIMER_W'(1);
      for (int i = 0; i < NUM_SW; i++) begin
        if (!raw_n[i]) begin
          if (deb_cnt[i] < DEB_MAX) deb_cnt[i] = deb_cnt[i] + CNT_W'(1);
        end else if (deb_cnt[i] != 0) begin
          deb_cnt[i] = deb_cnt[i] - CNT_W'(1);
        end
      end
      if (seq_mode != MODE_IDLE) oc = seq_advance(raw_n);
      else drive_lvl = DRV_STOP;
    end else if ((op == OP_UNLOCK || op == OP_LOCK) && seq_mode == MODE_IDLE) begin
      seq_mode = (op == OP_UNLOCK) ? MODE_UNLOCK : MODE_LOCK;
      seq_step = ST_ENTRY;
    end
    r.motor_drive = drive_lvl;
    r.busy_res    = (seq_mode != MODE_IDLE);
    r.position    = bolt_position();
    r.outcome     = oc;
    return r;
  endfunction

  function automatic logic [31:0] cfg_get(reg_idx_e idx);
    case (idx)
      REG_HAND_LEFT:      return 32'(cfg.hand_left);
      REG_DRIVE_TIMEOUT:  return 32'(cfg.drive_timeout);
      REG_LOCK_SETTLE:    return 32'(cfg.lock_settle);
      REG_UNLOCK_SETTLE:  return 32'(cfg.unlock_settle);
      REG_LOCK_BACKOFF:   return 32'(cfg.lock_backoff);
      REG_UNLOCK_BACKOFF: return 32'(cfg.unlock_backoff);
      REG_FINAL_RUN:      return 32'(cfg.final_run);
      default:            return 32'(cfg.overrun_ticks);
    endcase
  endfunction

  function automatic void cfg_set(reg_idx_e idx, logic [31:0] val);
    case (idx)
      REG_HAND_LEFT:      cfg.hand_left      = val[0];
      REG_DRIVE_TIMEOUT:  cfg.drive_timeout  = val[TIMER_W-1:0];
      REG_LOCK_SETTLE:    cfg.lock_settle    = val[7:0];
      REG_UNLOCK_SETTLE:  cfg.unlock_settle  = val[7:0];
      REG_LOCK_BACKOFF:   cfg.lock_backoff   = val[7:0];
      REG_UNLOCK_BACKOFF: cfg.unlock_backoff = val[7:0];
      REG_FINAL_RUN:      cfg.final_run      = val[7:0];
      default:            cfg.overrun_ticks  = val[3:0];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  res_t pending_res_q[$];
  int   errors = 0;
  int   cycle_cnt = 0;
  bit   in_fire_s = 1'b0;
  bit   res_fire_s = 1'b0;
  res_t res_s;

  // outputs only move after a rising edge, so the falling edge sees them settled
  always @(negedge clk_i) begin
    in_fire_s  = rst_ni && in_valid_i && !in_stall_o;
    res_fire_s = rst_ni && out_valid_o && !out_stall_i;
    res_s      = {motor_drive_o, busy_res_o, position_o, outcome_o};
  end

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (pending_res_q.size() == 0) begin
      errors++;
      $display("%0t: result with no request pending, actual %p", $time, got);
    end else begin
      want = pending_res_q.pop_front();
      check_field("motor_drive", want.motor_drive, got.motor_drive);
      check_field("busy_res", 2'(want.busy_res), 2'(got.busy_res));
      check_field("position", want.position, got.position);
      check_field("outcome", want.outcome, got.outcome);
    end
  endtask

  always @(posedge clk_i) begin
    if (res_fire_s) check_result(res_s);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_res_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side stalling
  // ---------------------------------------------------------------------------
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  bit pressure_on   = 1'b0;
  bit pressure_done = 1'b0;
  int hold_cnt      = 0;

  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (pressure_on && !pressure_done && $urandom_range(19) == 0) begin
      // long hold-off: block buffer fills and in_stall_o must rise
      pressure_done <= 1'b1;
      hold_cnt      <= 80;
      out_stall_i   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [1:0] op, logic [3:0] raw_n, bit fixed, res_t fixed_res);
    int   gap;
    res_t want;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    left_level_n_i  <= raw_n[SW_LEFT];
    vertical_n_i    <= raw_n[SW_VERTICAL];
    right_level_n_i <= raw_n[SW_RIGHT];
    travel_n_i      <= raw_n[SW_TRAVEL];
    @(posedge clk_i);
    while (!in_fire_s) @(posedge clk_i);
    want = lock_seq_step(op, raw_n);
    pending_res_q.push_back(fixed ? fixed_res : want);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_res_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_access(reg_idx_e idx, bit wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_config();
    logic [31:0] rd;
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(reg_idx_e'(i), 1'b0, '0, rd);
      if (rd !== cfg_get(reg_idx_e'(i))) begin
        errors++;
        $display("%0t: register %0d readback, expected %0d actual %0d", $time,
                 i, cfg_get(reg_idx_e'(i)), rd);
      end
    end
  endtask

  task automatic load_config(int k);
    logic [31:0] v [NUM_REGS];
    logic [31:0] rd;
    if (k == 1) begin
      v = '{1, 1, 0, 0, 0, 0, 0, 0};
    end else if (k == 2) begin
      v = '{0, 1023, 255, 255, 255, 255, 255, 15};
    end else begin
      v = '{$urandom_range(1), $urandom_range(1, 60), $urandom_range(30),
            $urandom_range(30), $urandom_range(30), $urandom_range(30),
            $urandom_range(30), $urandom_range(15)};
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_access(reg_idx_e'(i), 1'b1, v[i], rd);
      cfg_set(reg_idx_e'(i), v[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus: switch levels follow the running sequence so that most
  // sequences get through every step; stuck switches force the timeouts.
  // ---------------------------------------------------------------------------
  logic [3:0] sw_lvl = 4'b1111;
  fault_e     fault  = FAULT_NONE;

  function automatic void place_bolt(logic [1:0] pos);
    sw_lvl[SW_LEFT]     = 1'b1;
    sw_lvl[SW_VERTICAL] = 1'b1;
    sw_lvl[SW_RIGHT]    = 1'b1;
    case (pos)
      POS_LOCKED:   sw_lvl[lock_sw()]   = 1'b0;
      POS_UNLOCKED: sw_lvl[SW_VERTICAL] = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void evolve_switches();
    for (int i = 0; i < NUM_SW; i++) begin
      if (!(fault == FAULT_TRAVEL_STUCK && i == SW_TRAVEL) && $urandom_range(39) == 0)
        sw_lvl[i] = ~sw_lvl[i];
    end
    if (seq_mode == MODE_IDLE) begin
      if ($urandom_range(29) == 0) begin
        case ($urandom_range(2))
          0:       place_bolt(POS_LOCKED);
          1:       place_bolt(POS_UNLOCKED);
          default: place_bolt(POS_MIDDLE);
        endcase
      end
    end else if (seq_step == ST_RUN && fault != FAULT_END_STUCK) begin
      if ($urandom_range(3) == 0)
        place_bolt(seq_mode == MODE_LOCK ? POS_LOCKED : POS_UNLOCKED);
    end else if ((seq_step == ST_BACKOFF || seq_step == ST_SEEKBACK) &&
                 fault != FAULT_TRAVEL_STUCK) begin
      if ($urandom_range(4) == 0) sw_lvl[SW_TRAVEL] = ~sw_lvl[SW_TRAVEL];
    end
  endfunction

  task automatic pick_request(output logic [1:0] op, output logic [3:0] raw_n);
    int roll;
    roll = $urandom_range(99);
    if (seq_mode == MODE_IDLE && roll < 30) begin
      op = $urandom_range(1) ? OP_LOCK : OP_UNLOCK;
      case ($urandom_range(5))
        0:       fault = FAULT_END_STUCK;
        1:       fault = FAULT_TRAVEL_STUCK;
        default: fault = FAULT_NONE;
      endcase
      if (fault == FAULT_TRAVEL_STUCK) sw_lvl[SW_TRAVEL] = 1'b0;
      raw_n = 4'($urandom);
    end else if (roll < 33) begin
      // stray command: ignored while busy, reserved code always ignored
      case ($urandom_range(2))
        0:       op = OP_UNLOCK;
        1:       op = OP_LOCK;
        default: op = OP_RSVD;
      endcase
      raw_n = 4'($urandom);
    end else begin
      op = OP_TICK;
      evolve_switches();
      raw_n = sw_lvl;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed requests, default configuration (right-opening door)
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [NUM_DIR] = '{
    '{OP_TICK,   4'b1111, 1'b1, '{DRV_STOP, 1'b0, POS_MIDDLE,   OUT_NONE}},
    '{OP_RSVD,   4'b0000, 1'b1, '{DRV_STOP, 1'b0, POS_MIDDLE,   OUT_NONE}},
    // vertical switch held active until it debounces on
    '{OP_TICK,   4'b1101, 1'b0, '0},
    '{OP_TICK,   4'b1101, 1'b0, '0},
    '{OP_TICK,   4'b1101, 1'b0, '0},
    '{OP_TICK,   4'b1101, 1'b0, '0},
    '{OP_TICK,   4'b1101, 1'b0, '0},
    '{OP_TICK,   4'b1101, 1'b0, '0},
    '{OP_UNLOCK, 4'b1101, 1'b1, '{DRV_STOP, 1'b1, POS_UNLOCKED, OUT_NONE}},
    '{OP_LOCK,   4'b0000, 1'b1, '{DRV_STOP, 1'b1, POS_UNLOCKED, OUT_NONE}},
    '{OP_TICK,   4'b1101, 1'b1, '{DRV_STOP, 1'b0, POS_UNLOCKED, OUT_THERE}},
    // lock: raw end-switch hit, overrun, then settle
    '{OP_LOCK,   4'b1111, 1'b0, '0},
    '{OP_TICK,   4'b1111, 1'b0, '0},
    '{OP_TICK,   4'b1011, 1'b0, '0},
    '{OP_TICK,   4'b1011, 1'b0, '0},
    '{OP_TICK,   4'b1011, 1'b0, '0},
    '{OP_UNLOCK, 4'b0101, 1'b0, '0}
  };

  initial begin
    logic [1:0] op;
    logic [3:0] raw_n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_config();
    for (int r = 0; r < NUM_DIR; r++)
      send_request(dir_tab[r].op, dir_tab[r].raw_n, dir_tab[r].fixed, dir_tab[r].res);
    for (int k = 0; k < NUM_PHASES; k++) begin
      drain();
      if (k != 0) begin
        load_config(k);
        check_config();
      end
      case (k % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 79; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 79; end
        default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
      endcase
      pressure_on = (k == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_request(op, raw_n);
        send_request(op, raw_n, 1'b0, '0);
      end
    end
    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending_res_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lmds_pkg.sv
sv/lmds_seq.sv
sv/lock_motor_drive_sequencer_core.sv
tb/tb_top.sv
